// File: src/esfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esfd_pkg
// Shared types and constants of the escaped sample frame decoder.
// ----------------------------------------------------------------------------
package esfd_pkg;

  // escape marker length in bytes
  localparam int MARKER_LEN  = 6;
  // longest message body kept before the escape is forced closed
  localparam int MAX_MESSAGE = 64;
  // channels per frame at most
  localparam int CHANNELS    = 8;
  // bytes of the message head compared against the event tag
  localparam int HEAD_LEN    = 5;
  // depth of the op queue between front and back
  localparam int FIFO_DEPTH  = 4;

  // mean filter weight, 0.0001 in q24
  localparam logic [10:0] ALPHA_Q = 11'd1678;

  // event tag "EVNT:", first byte in the low bits
  localparam logic [HEAD_LEN-1:0][7:0] EVNT_TAG = {8'h3A, 8'h54, 8'h4E, 8'h56, 8'h45};

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_CHANNELS = 2'd0,
    CFG_START    = 2'd1,
    CFG_END      = 2'd2
  } cfg_index_t;

  // work handed from front to back
  typedef enum logic [1:0] {
    OP_NOP    = 2'd0,
    OP_DECODE = 2'd1,
    OP_EVENT  = 2'd2
  } op_kind_t;

  typedef struct packed {
    op_kind_t    kind;
    logic [7:0]  data;
    logic        clr;   // clear position counts before this op
    logic        eoi;   // final op of one input beat
  } op_t;

  typedef struct packed {
    logic        kind;
    logic [2:0]  channel;
    logic [15:0] sample_value;
    logic [15:0] position;
    logic        last;
  } res_t;

endpackage

// File: src/esfd_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esfd_in_if
// Input byte channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface esfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       batch_first;

  modport source (output valid, output data_byte, output batch_first, input ready);
  modport sink   (input valid, input data_byte, input batch_first, output ready);
endinterface

// File: src/esfd_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esfd_out_if
// Result channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface esfd_out_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [2:0]         channel;
  logic signed [15:0] sample_value;
  logic [15:0]        position;
  logic               last;

  modport source (output valid, output kind, output channel, output sample_value,
                  output position, output last, input ready);
  modport sink   (input valid, input kind, input channel, input sample_value,
                  input position, input last, output ready);
endinterface

// File: src/esfd_op_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esfd_op_fifo
// Short queue of ops between the front and the back.
// ----------------------------------------------------------------------------
module esfd_op_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  esfd_pkg::op_t push_data,
  output logic          full,
  input  logic          pop,
  output esfd_pkg::op_t pop_data,
  output logic          empty
);

  localparam int PW = $clog2(esfd_pkg::FIFO_DEPTH);

  esfd_pkg::op_t mem_r [esfd_pkg::FIFO_DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [PW:0]   count_r;

  assign full     = (count_r == (PW+1)'(esfd_pkg::FIFO_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  // pointer and fill tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push && !full) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop && !empty) rd_ptr_r <= rd_ptr_r + 1'b1;
      if ((push && !full) && !(pop && !empty)) count_r <= count_r + 1'b1;
      else if (!(push && !full) && (pop && !empty)) count_r <= count_r - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push && !full) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

// File: src/esfd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esfd_front
// Escape marker matching and message capture; turns each input beat into
// a short run of ops (held byte replay, decode, event, nothing).
// ----------------------------------------------------------------------------
module esfd_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [47:0]   cfg_wdata,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_data_byte,
  input  logic          in_batch_first,
  output logic          op_push,
  output esfd_pkg::op_t op_data,
  input  logic          op_full
);

  logic [esfd_pkg::MARKER_LEN-1:0][7:0] start_m_r;
  logic [esfd_pkg::MARKER_LEN-1:0][7:0] end_m_r;
  logic                                 in_esc_r;
  logic [2:0]                           mpos_r;
  logic [2:0]                           hcnt_r;
  logic [6:0]                           mlen_r;
  logic [7:0]                           held_r [esfd_pkg::MARKER_LEN];
  logic [esfd_pkg::HEAD_LEN-1:0][7:0]   head_r;
  logic                                 busy_r;
  logic [2:0]                           ridx_r;
  logic [2:0]                           rcnt_r;
  logic [7:0]                           cur_r;
  logic                                 clr_r;
  esfd_pkg::op_kind_t                   fkind_r;

  logic               in_esc_nxt;
  logic [2:0]         mpos_nxt;
  logic [2:0]         hcnt_nxt;
  logic [6:0]         mlen_nxt;
  logic [2:0]         rcnt_nxt;
  esfd_pkg::op_kind_t fkind_nxt;

  logic acc;
  logic s_hit;
  logic e_hit;
  logic is_evt;
  logic replay;
  logic mpos_ok;

  assign in_ready = !busy_r;
  assign acc      = in_valid && !busy_r;
  assign mpos_ok  = (mpos_r < 3'(esfd_pkg::MARKER_LEN));
  assign s_hit    = mpos_ok && (start_m_r[mpos_r] == in_data_byte);
  assign e_hit    = mpos_ok && (end_m_r[mpos_r] == in_data_byte);
  assign is_evt   = (mlen_r >= 7'(esfd_pkg::HEAD_LEN)) && (head_r == esfd_pkg::EVNT_TAG);

  // op out of the replay sequencer
  assign replay          = (ridx_r < rcnt_r);
  assign op_push         = busy_r && !op_full;
  assign op_data.kind    = replay ? esfd_pkg::OP_DECODE : fkind_r;
  assign op_data.data    = replay ? held_r[ridx_r] : cur_r;
  assign op_data.clr     = clr_r;
  assign op_data.eoi     = !replay;

  // marker state for the beat being accepted
  always_comb begin
    in_esc_nxt = in_esc_r;
    mpos_nxt   = mpos_r;
    hcnt_nxt   = hcnt_r;
    mlen_nxt   = mlen_r;
    rcnt_nxt   = '0;
    fkind_nxt  = esfd_pkg::OP_NOP;
    if (in_esc_r) begin
      if (mlen_r >= 7'(esfd_pkg::MAX_MESSAGE)) begin
        // overlong message: byte discarded, escape closed
        fkind_nxt  = is_evt ? esfd_pkg::OP_EVENT : esfd_pkg::OP_NOP;
        in_esc_nxt = 1'b0;
        mpos_nxt   = '0;
        hcnt_nxt   = '0;
        mlen_nxt   = '0;
      end else if (e_hit) begin
        if (mpos_r == 3'(esfd_pkg::MARKER_LEN - 1)) begin
          fkind_nxt  = is_evt ? esfd_pkg::OP_EVENT : esfd_pkg::OP_NOP;
          in_esc_nxt = 1'b0;
          mpos_nxt   = '0;
          hcnt_nxt   = '0;
          mlen_nxt   = '0;
        end else begin
          mpos_nxt = mpos_r + 1'b1;
        end
      end else begin
        mlen_nxt = mlen_r + 1'b1;
      end
    end else if (s_hit) begin
      if (mpos_r == 3'(esfd_pkg::MARKER_LEN - 1)) begin
        mpos_nxt   = '0;
        hcnt_nxt   = '0;
        in_esc_nxt = 1'b1;
      end else begin
        hcnt_nxt = hcnt_r + 1'b1;
        mpos_nxt = mpos_r + 1'b1;
      end
    end else begin
      // marker broken: replay held bytes then this one
      rcnt_nxt  = hcnt_r;
      fkind_nxt = esfd_pkg::OP_DECODE;
      mpos_nxt  = '0;
      hcnt_nxt  = '0;
      mlen_nxt  = '0;
    end
  end

  // marker state and op sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_m_r <= '0;
      end_m_r   <= '0;
      in_esc_r  <= 1'b0;
      mpos_r    <= '0;
      hcnt_r    <= '0;
      mlen_r    <= '0;
      busy_r    <= 1'b0;
      ridx_r    <= '0;
      rcnt_r    <= '0;
      clr_r     <= 1'b0;
      fkind_r   <= esfd_pkg::OP_NOP;
      cur_r     <= '0;
    end else begin
      if (cfg_we && (cfg_index == esfd_pkg::CFG_START)) start_m_r <= cfg_wdata;
      if (cfg_we && (cfg_index == esfd_pkg::CFG_END))   end_m_r   <= cfg_wdata;

      if (acc) begin
        busy_r   <= 1'b1;
        cur_r    <= in_data_byte;
        clr_r    <= in_batch_first;
        ridx_r   <= '0;
        rcnt_r   <= rcnt_nxt;
        fkind_r  <= fkind_nxt;
        in_esc_r <= in_esc_nxt;
        mpos_r   <= mpos_nxt;
        hcnt_r   <= hcnt_nxt;
        mlen_r   <= mlen_nxt;
      end else if (busy_r && !op_full) begin
        clr_r <= 1'b0;
        if (replay) ridx_r <= ridx_r + 1'b1;
        else busy_r <= 1'b0;
      end
    end
  end

  // held marker bytes and message head
  always_ff @(posedge clk) begin
    if (acc && !in_esc_r && s_hit && (hcnt_r < 3'(esfd_pkg::MARKER_LEN))) begin
      held_r[hcnt_r] <= in_data_byte;
    end
    if (acc && in_esc_r && (mlen_r < 7'(esfd_pkg::HEAD_LEN)) && !e_hit) begin
      head_r[mlen_r[2:0]] <= in_data_byte;
    end
  end

endmodule

// File: src/esfd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esfd_back
// Frame decoder, running mean removal, position counts and result staging.
// ----------------------------------------------------------------------------
module esfd_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [3:0]     cfg_channels,
  input  logic           op_valid,
  input  esfd_pkg::op_t  op_data,
  output logic           op_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output esfd_pkg::res_t out_res
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_MATH  = 3'b010,
    S_FLUSH = 3'b100
  } state_t;

  state_t               state_r;
  logic [3:0]           cc_r;
  logic                 fo_r;
  logic                 so_r;
  logic [2:0]           ach_r;
  logic [7:0]           high_r;
  logic signed [47:0]   mean_r;
  logic [15:0]          cnt_r [esfd_pkg::CHANNELS];
  logic signed [15:0]   s_r;
  logic signed [59:0]   mprod_r;
  logic signed [27:0]   sprod_r;
  logic                 eoi_r;
  logic                 pend_valid_r;
  esfd_pkg::res_t       pend_r;
  logic                 out_valid_r;
  esfd_pkg::res_t       out_r;

  logic               oslot;
  logic               take;
  logic               smp_done;
  logic               out_load;
  logic [7:0]         b;
  logic [15:0]        w;
  logic signed [15:0] s_nxt;
  logic [2:0]         last_ch;
  logic [15:0]        cur_cnt;
  logic [15:0]        evt_cnt;
  logic signed [59:0] dec;
  logic signed [49:0] sum;
  logic signed [47:0] mean_nxt;
  logic signed [48:0] adj;
  logic signed [48:0] ip;
  esfd_pkg::res_t     smp_res;
  esfd_pkg::res_t     evt_res;
  esfd_pkg::res_t     pend_last;

  assign oslot     = !out_valid_r || out_ready;
  assign take      = (state_r == S_IDLE) && op_valid && oslot;
  assign op_pop    = take;
  assign out_valid = out_valid_r;
  assign out_res   = out_r;
  assign b         = op_data.data;

  // low byte that completes a sample
  assign smp_done  = (op_data.kind == esfd_pkg::OP_DECODE) && fo_r && so_r && !b[7];

  // a staged result moves to the output register
  assign out_load  = pend_valid_r &&
                     ((take && (op_data.kind == esfd_pkg::OP_EVENT)) ||
                      ((state_r == S_MATH) && oslot) ||
                      ((state_r == S_FLUSH) && oslot));

  // raw sample, offset and gain, wrapped to 16 bits
  assign w     = 16'(({2'b00, high_r[6:0], b[6:0]} - 16'd512) * 16'd30);
  assign s_nxt = $signed(w);

  // last channel index of a frame
  always_comb begin
    if (cc_r == 4'd0) last_ch = 3'd0;
    else if (cc_r > 4'(esfd_pkg::CHANNELS)) last_ch = 3'(esfd_pkg::CHANNELS - 1);
    else last_ch = 3'(cc_r - 4'd1);
  end

  // mean update, saturation and integer part
  assign cur_cnt = cnt_r[ach_r];
  assign evt_cnt = op_data.clr ? 16'd0 : cur_cnt;
  assign dec     = (mprod_r + 60'sd8388608) >>> 24;
  assign sum     = {{2{mean_r[47]}}, mean_r} + {{22{sprod_r[27]}}, sprod_r} - dec[49:0];
  always_comb begin
    if (sum[49:47] == 3'b000 || sum[49:47] == 3'b111) mean_nxt = sum[47:0];
    else if (sum[49]) mean_nxt = {1'b1, 47'd0};
    else mean_nxt = {1'b0, {47{1'b1}}};
  end
  assign adj = {mean_nxt[47], mean_nxt} + (mean_nxt[47] ? 49'sd16777215 : 49'sd0);
  assign ip  = adj >>> 24;

  // result records
  assign smp_res.kind         = 1'b0;
  assign smp_res.channel      = ach_r;
  assign smp_res.sample_value = 16'(s_r - ip[15:0]);
  assign smp_res.position     = cur_cnt;
  assign smp_res.last         = 1'b0;
  assign evt_res.kind         = 1'b1;
  assign evt_res.channel      = ach_r;
  assign evt_res.sample_value = '0;
  assign evt_res.position     = (evt_cnt == 16'd0) ? 16'd0 : 16'(evt_cnt - 16'd1);
  assign evt_res.last         = 1'b0;

  // staged result tagged as the final one of its beat
  always_comb begin
    pend_last      = pend_r;
    pend_last.last = 1'b1;
  end

  // op execution
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cc_r         <= 4'd1;
      fo_r         <= 1'b0;
      so_r         <= 1'b0;
      ach_r        <= '0;
      high_r       <= '0;
      mean_r       <= '0;
      for (int i = 0; i < esfd_pkg::CHANNELS; i++) cnt_r[i] <= '0;
      eoi_r        <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;

      if (cfg_we && (cfg_index == esfd_pkg::CFG_CHANNELS)) begin
        cc_r  <= cfg_channels;
        fo_r  <= 1'b0;
        so_r  <= 1'b0;
        ach_r <= '0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (take) begin
            if (op_data.clr) begin
              for (int i = 0; i < esfd_pkg::CHANNELS; i++) cnt_r[i] <= '0;
            end
            state_r <= smp_done ? S_MATH : (op_data.eoi ? S_FLUSH : S_IDLE);
            unique case (op_data.kind)
              esfd_pkg::OP_DECODE: begin
                if (!fo_r) begin
                  high_r <= b;
                  if (b[7]) begin
                    ach_r <= '0;
                    fo_r  <= 1'b1;
                    so_r  <= 1'b1;
                  end else begin
                    fo_r  <= 1'b0;
                    so_r  <= 1'b0;
                    ach_r <= '0;
                  end
                end else if (!so_r) begin
                  high_r <= b;
                  if (b[7]) begin
                    fo_r  <= 1'b0;
                    so_r  <= 1'b0;
                    ach_r <= '0;
                  end else begin
                    ach_r <= ach_r + 1'b1;
                    so_r  <= 1'b1;
                  end
                end else if (b[7]) begin
                  fo_r  <= 1'b0;
                  so_r  <= 1'b0;
                  ach_r <= '0;
                end else begin
                  // low byte completes a sample: multiply now, finish in S_MATH once the output slot is free
                  s_r     <= s_nxt;
                  mprod_r <= $signed({{12{mean_r[47]}}, mean_r}) *
                             $signed({49'd0, esfd_pkg::ALPHA_Q});
                  sprod_r <= $signed({{12{s_nxt[15]}}, s_nxt}) *
                             $signed({17'd0, esfd_pkg::ALPHA_Q});
                  eoi_r   <= op_data.eoi;
                end
              end
              esfd_pkg::OP_EVENT: begin
                if (pend_valid_r) begin
                  out_r <= pend_r;
                end
                pend_r       <= evt_res;
                pend_valid_r <= 1'b1;
              end
              default: begin
              end
            endcase
          end
        end
        S_MATH: begin
          if (oslot) begin
            mean_r <= mean_nxt;
            if (pend_valid_r) begin
              out_r <= pend_r;
            end
            pend_r       <= smp_res;
            pend_valid_r <= 1'b1;
            if (cur_cnt != 16'hFFFF) cnt_r[ach_r] <= cur_cnt + 16'd1;
            so_r <= 1'b0;
            if (ach_r >= last_ch) fo_r <= 1'b0;
            state_r <= eoi_r ? S_FLUSH : S_IDLE;
          end
        end
        S_FLUSH: begin
          // final result of the beat goes out tagged last
          if (!pend_valid_r) begin
            state_r <= S_IDLE;
          end else if (oslot) begin
            out_r        <= pend_last;
            pend_valid_r <= 1'b0;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// File: src/escaped_sample_frame_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escaped_sample_frame_decoder_core
// Decodes escaped multichannel sample frames into samples and event markers.
// ----------------------------------------------------------------------------
// path: a beat's ops go through the front's op register and the op queue; the
//   back stages each result (a sample first passes S_MATH) ahead of the output
//   register; the front accepts no byte while it still hands out ops, and the
//   back takes an op only when idle with a free output slot; a broken marker
//   replays up to five held bytes, one op per cycle while the queue has room
// reset: synchronous active low, clears all control state and position counts
module escaped_sample_frame_decoder_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_wdata,
  esfd_in_if.sink     in_ch,
  esfd_out_if.source  out_ch
);

  esfd_pkg::op_t  push_op;
  esfd_pkg::op_t  pop_op;
  esfd_pkg::res_t res;
  logic           op_push;
  logic           op_full;
  logic           op_pop;
  logic           op_empty;

  // marker matching and op generation
  esfd_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_data_byte   (in_ch.data_byte),
    .in_batch_first (in_ch.batch_first),
    .op_push        (op_push),
    .op_data        (push_op),
    .op_full        (op_full)
  );

  // op queue
  esfd_op_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (op_push),
    .push_data (push_op),
    .full      (op_full),
    .pop       (op_pop),
    .pop_data  (pop_op),
    .empty     (op_empty)
  );

  // decode and result staging
  esfd_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_channels (cfg_wdata[3:0]),
    .op_valid     (!op_empty),
    .op_data      (pop_op),
    .op_pop       (op_pop),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_res      (res)
  );

  // result beat fields
  assign out_ch.kind         = res.kind;
  assign out_ch.channel      = res.channel;
  assign out_ch.sample_value = $signed(res.sample_value);
  assign out_ch.position     = res.position;
  assign out_ch.last         = res.last;

endmodule
